FILE: sv/css_pkg.sv
// Shared types, character codes and helpers for the colour string parser.
// No dependencies; imported by the channel interfaces, the top level and the checker.
`default_nettype none

package css_pkg;

  localparam int CHAR_W = 8;
  localparam int CHAN_W = 8;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [CHAN_W-1:0] chan_t;

  // ASCII codes used by the grammar
  localparam char_t CH_HASH   = 8'h23;
  localparam char_t CH_LPAREN = 8'h28;
  localparam char_t CH_RPAREN = 8'h29;
  localparam char_t CH_COMMA  = 8'h2C;
  localparam char_t CH_DOT    = 8'h2E;
  localparam char_t CH_SPACE  = 8'h20;
  localparam char_t CH_ZERO   = 8'h30;
  localparam char_t CH_NINE   = 8'h39;
  localparam char_t CH_LO_A   = 8'h61;
  localparam char_t CH_LO_B   = 8'h62;
  localparam char_t CH_LO_F   = 8'h66;
  localparam char_t CH_LO_G   = 8'h67;
  localparam char_t CH_LO_R   = 8'h72;
  localparam char_t CH_UP_A   = 8'h41;
  localparam char_t CH_UP_F   = 8'h46;

  localparam chan_t CHAN_MAX = 8'hFF;

  // Hex digit value, anything that is not a hex digit counts as zero
  function automatic logic [3:0] hex_nibble(input char_t c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = c[3:0];
    end else if ((c >= CH_LO_A && c <= CH_LO_F) || (c >= CH_UP_A && c <= CH_UP_F)) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

  // Expand one nibble to a full 8-bit code (0xA -> 0xAA)
  function automatic chan_t nib_pair(input logic [3:0] n);
    return {n, n};
  endfunction

endpackage

`default_nettype wire

FILE: sv/css_in_if.sv
// Input channel: one character of the colour string per transaction.
// Depends on css_pkg for the character type.
`default_nettype none

interface css_in_if
  import css_pkg::*;
;
  logic  valid;
  logic  ready;
  char_t char_code;
  logic  last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

FILE: sv/css_out_if.sv
// Result channel: RGBA codes and ok flag, one transaction per string.
// Depends on css_pkg for the channel type.
`default_nettype none

interface css_out_if
  import css_pkg::*;
;
  logic  valid;
  logic  ready;
  chan_t red;
  chan_t green;
  chan_t blue;
  chan_t alpha;
  logic  ok;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output ok, input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  input ok, output ready);
endinterface

`default_nettype wire

FILE: sv/css_color_string_parser.sv
// CSS colour string parser: character register, parse logic, result register.
// Depends on css_pkg, css_in_if and css_out_if.
//
// Usage
//   in_chan takes one ASCII character per transaction; last_char marks the
//   end of a string. Only the transaction carrying last_char produces a
//   result on out_chan: red, green, blue, alpha and ok (all zero when ok=0).
//   Forms: #rgb, #rgba, #rrggbb, #rrggbbaa, rgb(r,g,b), rgba(r,g,b,a).
// Timing
//   A character is captured in an input register, then parsed by one pass
//   of combinational logic that updates the parser state and, on the last
//   character, loads the result register, which drives out_chan.valid.
//   Throughput is one character per cycle, set by the single parse pass,
//   while no last character waits for a pending result; alpha is built up
//   one fraction digit per character from a constant table, so no divider
//   sits on the path.
// Reset and stalls
//   Synchronous reset empties both registers and returns the parser to the
//   start of a string. When out_chan stalls with a result pending, characters
//   that make no result still flow; a further last character waits in the
//   input register, and in_chan.ready drops until the result is taken.
`default_nettype none

module css_color_string_parser
  import css_pkg::*;
#(
  parameter int ALPHA_FRAC_DIGITS = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  css_in_if.sink    in_chan,
  css_out_if.source out_chan
);

  // Parser phases
  localparam logic [3:0] PH_START = 4'd0;
  localparam logic [3:0] PH_HEX   = 4'd1;
  localparam logic [3:0] PH_R     = 4'd2;
  localparam logic [3:0] PH_RG    = 4'd3;
  localparam logic [3:0] PH_RGB   = 4'd4;
  localparam logic [3:0] PH_RGBA  = 4'd5;
  localparam logic [3:0] PH_COMP3 = 4'd6;
  localparam logic [3:0] PH_COMP4 = 4'd7;
  localparam logic [3:0] PH_SEP3  = 4'd8;
  localparam logic [3:0] PH_SEP4  = 4'd9;
  localparam logic [3:0] PH_AINT  = 4'd10;
  localparam logic [3:0] PH_AFRAC = 4'd11;
  localparam logic [3:0] PH_TAIL  = 4'd12;
  localparam logic [3:0] PH_DONE  = 4'd13;

  // Alpha fraction scaling: alpha = floor(255 * F / FracScale)
  function automatic longint pow10(input int n);
    longint p;
    p = 1;
    for (int i = 0; i < n; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

  localparam longint FracScale = pow10(ALPHA_FRAC_DIGITS);
  localparam int     RemW      = $clog2(FracScale);
  localparam int     FdW       = $clog2(ALPHA_FRAC_DIGITS + 1);
  localparam int     FdRows    = 2 ** FdW;

  // Per digit position and value: quotient and remainder of
  // 255 * d * 10^(digits-1-pos) over FracScale
  logic [CHAN_W-1:0] frac_q_tab [FdRows][10];
  logic [RemW-1:0]   frac_r_tab [FdRows][10];

  for (genvar k = 0; k < FdRows; k++) begin : g_frac_row
    for (genvar d = 0; d < 10; d++) begin : g_frac_col
      localparam longint Num = (k < ALPHA_FRAC_DIGITS) ?
                               255 * d * pow10(ALPHA_FRAC_DIGITS - 1 - k) : 0;
      assign frac_q_tab[k][d] = CHAN_W'(Num / FracScale);
      assign frac_r_tab[k][d] = RemW'(Num % FracScale);
    end
  end

  // Input register
  logic  st_valid_r;
  char_t st_char_r;
  logic  st_last_r;
  logic  fire;

  // Parser state
  logic [3:0]        ph_r,  ph_nxt;
  logic [3:0]        cc_r,  cc_nxt;
  logic [31:0]       hw_r,  hw_nxt;
  logic [CHAN_W-1:0] acc_r, acc_nxt;
  logic [CHAN_W-1:0] ch_r [3];
  logic [CHAN_W-1:0] ch_nxt [3];
  logic [2:0]        ct_r,  ct_nxt;
  logic              ds_r,  ds_nxt;
  logic              awn_r, awn_nxt;
  logic [CHAN_W-1:0] aq_r,  aq_nxt;
  logic [RemW-1:0]   ar_r,  ar_nxt;
  logic [FdW-1:0]    fd_r,  fd_nxt;
  logic              err_r, err_nxt;

  // Result register
  logic  out_valid_r;
  chan_t red_r, green_r, blue_r, alpha_r;
  logic  ok_r;
  chan_t red_nxt, green_nxt, blue_nxt, alpha_nxt;
  logic  ok_nxt;

  // Handshake: the parse step stalls only for a last character with the
  // result slot full and not draining
  assign fire          = st_valid_r && (!st_last_r || !out_valid_r || out_chan.ready);
  assign in_chan.ready = !st_valid_r || fire;

  // Parse step
  logic       is_dig, four;
  logic [3:0] dval;
  logic [3:0] cc_inc;
  logic [11:0] acc_wide;
  logic [RemW:0] rem_sum;
  char_t c;

  always_comb begin
    c        = st_char_r;
    is_dig   = c inside {[CH_ZERO:CH_NINE]};
    dval     = c[3:0];
    four     = (ph_r == PH_COMP4) || (ph_r == PH_SEP4);
    cc_inc   = cc_r + 4'd1;
    acc_wide = 12'(acc_r) * 12'd10 + 12'(dval);
    rem_sum  = (RemW+1)'(ar_r) + (RemW+1)'(frac_r_tab[fd_r][dval]);

    ph_nxt  = ph_r;
    cc_nxt  = cc_r;
    hw_nxt  = hw_r;
    acc_nxt = acc_r;
    ch_nxt  = ch_r;
    ct_nxt  = ct_r;
    ds_nxt  = ds_r;
    awn_nxt = awn_r;
    aq_nxt  = aq_r;
    ar_nxt  = ar_r;
    fd_nxt  = fd_r;
    err_nxt = err_r;

    if (!err_r) begin
      case (ph_r)
        PH_START: begin
          if (c == CH_HASH) begin
            ph_nxt = PH_HEX;
            cc_nxt = 4'd1;
          end else if (c == CH_LO_R) begin
            ph_nxt = PH_R;
          end else begin
            err_nxt = 1'b1;
          end
        end
        PH_HEX: begin
          if (cc_r >= 4'd9) begin
            err_nxt = 1'b1;
          end else begin
            hw_nxt = {hw_r[27:0], hex_nibble(c)};
            cc_nxt = cc_inc;
          end
        end
        PH_R: begin
          if (c == CH_LO_G) ph_nxt = PH_RG;
          else err_nxt = 1'b1;
        end
        PH_RG: begin
          if (c == CH_LO_B) ph_nxt = PH_RGB;
          else err_nxt = 1'b1;
        end
        PH_RGB, PH_RGBA: begin
          if (c == CH_LO_A && ph_r == PH_RGB) begin
            ph_nxt = PH_RGBA;
          end else if (c != CH_LPAREN) begin
            err_nxt = 1'b1;
          end else begin
            ph_nxt  = (ph_r == PH_RGB) ? PH_COMP3 : PH_COMP4;
            cc_nxt  = 4'd0;
            acc_nxt = '0;
            ds_nxt  = 1'b0;
          end
        end
        PH_COMP3, PH_COMP4: begin
          if (is_dig) begin
            // decimal component, saturating at 255
            acc_nxt = (acc_wide > 12'd255) ? CHAN_MAX : acc_wide[CHAN_W-1:0];
            ds_nxt  = 1'b1;
          end else if (!ds_r || cc_r > 4'd2) begin
            err_nxt = 1'b1;
          end else begin
            ch_nxt[cc_r[1:0]] = acc_r;
            cc_nxt = cc_inc;
            if (!four && cc_inc == 4'd3) begin
              if (c == CH_SPACE) ph_nxt = PH_TAIL;
              else if (c == CH_RPAREN) ph_nxt = PH_DONE;
              else err_nxt = 1'b1;
            end else if (c == CH_SPACE || c == CH_COMMA) begin
              if (c == CH_COMMA && ct_r != 3'd7) ct_nxt = ct_r + 3'd1;
              ph_nxt = four ? PH_SEP4 : PH_SEP3;
            end else begin
              err_nxt = 1'b1;
            end
          end
        end
        PH_SEP3, PH_SEP4: begin
          if (c == CH_SPACE) begin
            ph_nxt = ph_r;
          end else if (c == CH_COMMA) begin
            if (ct_r != 3'd7) ct_nxt = ct_r + 3'd1;
          end else if (four && cc_r == 4'd3) begin
            cc_nxt = 4'd4;
            if (is_dig) begin
              ds_nxt  = 1'b1;
              awn_nxt = (c != CH_ZERO);
              ph_nxt  = PH_AINT;
            end else if (c == CH_DOT) begin
              ds_nxt = 1'b0;
              ph_nxt = PH_AFRAC;
            end else begin
              err_nxt = 1'b1;
            end
          end else if (is_dig) begin
            acc_nxt = CHAN_W'(dval);
            ds_nxt  = 1'b1;
            ph_nxt  = four ? PH_COMP4 : PH_COMP3;
          end else begin
            err_nxt = 1'b1;
          end
        end
        PH_AINT, PH_AFRAC: begin
          if (is_dig) begin
            ds_nxt = 1'b1;
            if (ph_r == PH_AINT) begin
              if (c != CH_ZERO) awn_nxt = 1'b1;
            end else if (fd_r < FdW'(ALPHA_FRAC_DIGITS)) begin
              // add this digit's share of 255*F, carry remainder overflow
              if (rem_sum >= (RemW+1)'(FracScale)) begin
                ar_nxt = RemW'(rem_sum - (RemW+1)'(FracScale));
                aq_nxt = aq_r + frac_q_tab[fd_r][dval] + CHAN_W'(1);
              end else begin
                ar_nxt = rem_sum[RemW-1:0];
                aq_nxt = aq_r + frac_q_tab[fd_r][dval];
              end
              fd_nxt = fd_r + FdW'(1);
            end
          end else if (c == CH_DOT && ph_r == PH_AINT) begin
            ph_nxt = PH_AFRAC;
          end else if (ds_r && c == CH_SPACE) begin
            ph_nxt = PH_TAIL;
          end else if (ds_r && c == CH_RPAREN) begin
            ph_nxt = PH_DONE;
          end else begin
            err_nxt = 1'b1;
          end
        end
        PH_TAIL: begin
          if (c == CH_RPAREN) ph_nxt = PH_DONE;
          else if (c != CH_SPACE) err_nxt = 1'b1;
        end
        default: begin
          err_nxt = 1'b1;
        end
      endcase
    end
  end

  // Result formation from the state after this character
  always_comb begin
    red_nxt   = '0;
    green_nxt = '0;
    blue_nxt  = '0;
    alpha_nxt = '0;
    ok_nxt    = 1'b0;
    if (!err_nxt && ph_nxt == PH_HEX) begin
      case (cc_nxt)
        4'd4: begin
          ok_nxt    = 1'b1;
          red_nxt   = nib_pair(hw_nxt[11:8]);
          green_nxt = nib_pair(hw_nxt[7:4]);
          blue_nxt  = nib_pair(hw_nxt[3:0]);
          alpha_nxt = CHAN_MAX;
        end
        4'd5: begin
          ok_nxt    = 1'b1;
          red_nxt   = nib_pair(hw_nxt[15:12]);
          green_nxt = nib_pair(hw_nxt[11:8]);
          blue_nxt  = nib_pair(hw_nxt[7:4]);
          alpha_nxt = nib_pair(hw_nxt[3:0]);
        end
        4'd7: begin
          ok_nxt    = 1'b1;
          red_nxt   = hw_nxt[23:16];
          green_nxt = hw_nxt[15:8];
          blue_nxt  = hw_nxt[7:0];
          alpha_nxt = CHAN_MAX;
        end
        4'd9: begin
          ok_nxt    = 1'b1;
          red_nxt   = hw_nxt[31:24];
          green_nxt = hw_nxt[23:16];
          blue_nxt  = hw_nxt[15:8];
          alpha_nxt = hw_nxt[7:0];
        end
        default: begin
          ok_nxt = 1'b0;
        end
      endcase
    end else if (!err_nxt && ph_nxt == PH_DONE) begin
      if (cc_nxt == 4'd3 && (ct_nxt == 3'd0 || ct_nxt == 3'd2)) begin
        ok_nxt    = 1'b1;
        alpha_nxt = CHAN_MAX;
      end else if (cc_nxt == 4'd4 && ct_nxt == 3'd3) begin
        ok_nxt    = 1'b1;
        alpha_nxt = awn_nxt ? CHAN_MAX : aq_nxt;
      end
      if (ok_nxt) begin
        red_nxt   = ch_nxt[0];
        green_nxt = ch_nxt[1];
        blue_nxt  = ch_nxt[2];
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      st_valid_r <= 1'b1;
    end else if (fire) begin
      st_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      st_char_r <= in_chan.char_code;
      st_last_r <= in_chan.last_char;
    end
  end

  // Parser state: cleared at reset and after every last character
  always_ff @(posedge clk) begin
    if (!rst_n || (fire && st_last_r)) begin
      ph_r  <= PH_START;
      cc_r  <= '0;
      hw_r  <= '0;
      acc_r <= '0;
      ch_r  <= '{default: '0};
      ct_r  <= '0;
      ds_r  <= 1'b0;
      awn_r <= 1'b0;
      aq_r  <= '0;
      ar_r  <= '0;
      fd_r  <= '0;
      err_r <= 1'b0;
    end else if (fire) begin
      ph_r  <= ph_nxt;
      cc_r  <= cc_nxt;
      hw_r  <= hw_nxt;
      acc_r <= acc_nxt;
      ch_r  <= ch_nxt;
      ct_r  <= ct_nxt;
      ds_r  <= ds_nxt;
      awn_r <= awn_nxt;
      aq_r  <= aq_nxt;
      ar_r  <= ar_nxt;
      fd_r  <= fd_nxt;
      err_r <= err_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && st_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && st_last_r) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      alpha_r <= alpha_nxt;
      ok_r    <= ok_nxt;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.red   = red_r;
  assign out_chan.green = green_r;
  assign out_chan.blue  = blue_r;
  assign out_chan.alpha = alpha_r;
  assign out_chan.ok    = ok_r;

endmodule

`default_nettype wire

FILE: sv/css_chk.sv
// Port-level checks for the colour string parser, bound to the top level.
// Depends on css_pkg and css_color_string_parser.
`default_nettype none

module css_chk
  import css_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst_n,
  input wire logic  out_valid,
  input wire logic  out_ready,
  input wire chan_t out_red,
  input wire chan_t out_green,
  input wire chan_t out_blue,
  input wire chan_t out_alpha,
  input wire logic  out_ok
);

  // Pending result is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_red) && $stable(out_green) &&
      $stable(out_blue) && $stable(out_alpha) && $stable(out_ok))
    else $error("result changed while stalled");

  // A rejected string reports all channels as zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_red == '0 && out_green == '0 &&
      out_blue == '0 && out_alpha == '0)
    else $error("non-zero channel on failed parse");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind css_color_string_parser css_chk u_css_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_red   (out_chan.red),
  .out_green (out_chan.green),
  .out_blue  (out_chan.blue),
  .out_alpha (out_chan.alpha),
  .out_ok    (out_chan.ok)
);

`default_nettype wire
